// ===== rtl/sipm_pkg.sv =====
// ----------------------------------------------------------------------------
// sipm_pkg: shared types and constants for the sparse index predecessor map
// Sizes of the entry table and summary store, status and command codes, and
// the packed item types of the input and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

package sipm_pkg;

  localparam int MAX_ENTRIES   = 65536;
  localparam int GRANULARITY   = 64;
  localparam int SUMMARY_DEPTH = (MAX_ENTRIES + GRANULARITY - 1) / GRANULARITY;

  localparam int KEY_W  = 48;
  localparam int OFS_W  = 32;
  localparam int FPOS_W = 40;
  localparam int ENT_W  = KEY_W + FPOS_W;

  localparam int ENT_AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int SUM_AW = (SUMMARY_DEPTH > 1) ? $clog2(SUMMARY_DEPTH) : 1;
  localparam int SUM_CW = $clog2(SUMMARY_DEPTH + 1);
  localparam int GRAN_W = $clog2(GRANULARITY);

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  typedef struct packed {
    logic              command;
    logic [KEY_W-1:0]  base_position;
    logic [OFS_W-1:0]  token_offset;
    logic [FPOS_W-1:0] file_position;
    logic [KEY_W-1:0]  query_position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [KEY_W-1:0]  found_index_position;
    logic [FPOS_W-1:0] found_file_position;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/sipm_ram.sv =====
// ----------------------------------------------------------------------------
// sipm_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sipm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/sparse_index_predecessor_map_top.sv =====
// ----------------------------------------------------------------------------
// sparse_index_predecessor_map_top: append-only key to file-position table
// with a two-level predecessor lookup (summary binary search, chunk scan).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_item carries one command per item:
//   append (key = base_position + token_offset, stored with file_position) or
//   lookup (last entry with key at or below query_position). Every item gives
//   exactly one result item on out_valid / out_stall / out_item.
//   Path: an append, or a lookup on an empty table, finishes without a read; a
//   query below the first key stops after the first summary read; otherwise the
//   lookup makes up to ceil(log2(chunks)) summary probes and then scans one
//   chunk, with one entry read per cycle in the scan.
//   One item is worked on at a time; in_stall stays high until the result is
//   loaded into the output register. A result held under out_stall waits there;
//   the next item is taken meanwhile and its result waits in the sequencer.
//   Reset empties the table (entry and summary counts cleared); no clearing
//   pass is needed, since only written entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_index_predecessor_map_top (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire sipm_pkg::in_item_t   in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output sipm_pkg::out_item_t       out_item
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_APPEND   = 3'd1;
  localparam logic [2:0] S_LK_START = 3'd2;
  localparam logic [2:0] S_LK_FIRST = 3'd3;
  localparam logic [2:0] S_BS_ISSUE = 3'd4;
  localparam logic [2:0] S_BS_WAIT  = 3'd5;
  localparam logic [2:0] S_SCAN     = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0]                     state;
  logic [sipm_pkg::CNT_W-1:0]     entry_count;
  logic [sipm_pkg::SUM_CW-1:0]    summary_count;
  logic [sipm_pkg::GRAN_W-1:0]    gran_cnt;

  logic [sipm_pkg::KEY_W:0]       key;
  logic [sipm_pkg::FPOS_W-1:0]    fpos;
  logic [sipm_pkg::KEY_W-1:0]     query;

  logic [sipm_pkg::SUM_AW-1:0]    lower;
  logic [sipm_pkg::SUM_AW-1:0]    upper;
  logic [sipm_pkg::SUM_AW-1:0]    mid_q;
  logic [sipm_pkg::CNT_W-1:0]     scan_idx;
  logic [sipm_pkg::CNT_W-1:0]     scan_end;
  logic                           rd_pend;

  sipm_pkg::out_item_t            res;

  logic [sipm_pkg::SUM_AW:0]      mid_sum;
  logic [sipm_pkg::SUM_AW-1:0]    mid;
  logic [sipm_pkg::CNT_W-1:0]     scan_start;
  logic [sipm_pkg::CNT_W:0]       chunk_end;
  logic                           out_free;

  logic                           ent_we;
  logic                           sum_we;
  logic [sipm_pkg::SUM_AW-1:0]    sum_raddr;
  logic [sipm_pkg::ENT_W-1:0]     ent_rdata;
  logic [sipm_pkg::KEY_W-1:0]     sum_rdata;
  logic [sipm_pkg::KEY_W-1:0]     ent_key;
  logic [sipm_pkg::FPOS_W-1:0]    ent_fpos;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign mid_sum    = {1'b0, upper} + {1'b0, lower} + (sipm_pkg::SUM_AW + 1)'(1);
  assign mid        = mid_sum[sipm_pkg::SUM_AW:1];
  assign scan_start = sipm_pkg::CNT_W'(sipm_pkg::CNT_W'(lower)
                                       * sipm_pkg::CNT_W'(sipm_pkg::GRANULARITY));
  assign chunk_end  = {1'b0, scan_start} + (sipm_pkg::CNT_W + 1)'(sipm_pkg::GRANULARITY);

  assign ent_key  = ent_rdata[sipm_pkg::ENT_W-1:sipm_pkg::FPOS_W];
  assign ent_fpos = ent_rdata[sipm_pkg::FPOS_W-1:0];

  // Append writes only when the table has room and the key fits.
  assign ent_we = (state == S_APPEND)
                  && (entry_count < sipm_pkg::CNT_W'(sipm_pkg::MAX_ENTRIES))
                  && !key[sipm_pkg::KEY_W];
  assign sum_we = ent_we && (gran_cnt == '0)
                  && (summary_count < sipm_pkg::SUM_CW'(sipm_pkg::SUMMARY_DEPTH));
  assign sum_raddr = (state == S_BS_ISSUE) ? mid : '0;

  sipm_ram #(
    .WIDTH (sipm_pkg::ENT_W),
    .DEPTH (sipm_pkg::MAX_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (entry_count[sipm_pkg::ENT_AW-1:0]),
    .wdata ({key[sipm_pkg::KEY_W-1:0], fpos}),
    .raddr (scan_idx[sipm_pkg::ENT_AW-1:0]),
    .rdata (ent_rdata)
  );

  sipm_ram #(
    .WIDTH (sipm_pkg::KEY_W),
    .DEPTH (sipm_pkg::SUMMARY_DEPTH)
  ) u_summary_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (summary_count[sipm_pkg::SUM_AW-1:0]),
    .wdata (key[sipm_pkg::KEY_W-1:0]),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  // Sequencer and table counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      entry_count   <= '0;
      summary_count <= '0;
      gran_cnt      <= '0;
      rd_pend       <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            key   <= {1'b0, in_item.base_position}
                     + (sipm_pkg::KEY_W + 1)'(in_item.token_offset);
            fpos  <= in_item.file_position;
            query <= in_item.query_position;
            state <= (in_item.command == sipm_pkg::CMD_APPEND) ? S_APPEND : S_LK_START;
          end
        end
        S_APPEND: begin
          if (entry_count >= sipm_pkg::CNT_W'(sipm_pkg::MAX_ENTRIES)) begin
            res <= '{status: sipm_pkg::ST_FULL, found_index_position: '0,
                     found_file_position: '0};
          end else if (key[sipm_pkg::KEY_W]) begin
            res <= '{status: sipm_pkg::ST_OVERFLOW, found_index_position: '0,
                     found_file_position: '0};
          end else begin
            res <= '{status: sipm_pkg::ST_OK,
                     found_index_position: key[sipm_pkg::KEY_W-1:0],
                     found_file_position: fpos};
            entry_count <= entry_count + sipm_pkg::CNT_W'(1);
            gran_cnt    <= (gran_cnt == sipm_pkg::GRAN_W'(sipm_pkg::GRANULARITY - 1))
                           ? '0 : gran_cnt + sipm_pkg::GRAN_W'(1);
            if (sum_we) begin
              summary_count <= summary_count + sipm_pkg::SUM_CW'(1);
            end
          end
          state <= S_DONE;
        end
        S_LK_START: begin
          if (entry_count == '0 || summary_count == '0) begin
            res   <= '{status: sipm_pkg::ST_NOT_FOUND, found_index_position: '0,
                       found_file_position: '0};
            state <= S_DONE;
          end else begin
            res   <= '{status: sipm_pkg::ST_OK, found_index_position: '0,
                       found_file_position: '0};
            state <= S_LK_FIRST;
          end
        end
        S_LK_FIRST: begin
          if (sum_rdata > query) begin
            res.status <= sipm_pkg::ST_NOT_FOUND;
            state      <= S_DONE;
          end else begin
            lower <= '0;
            upper <= sipm_pkg::SUM_AW'(summary_count - sipm_pkg::SUM_CW'(1));
            state <= S_BS_ISSUE;
          end
        end
        S_BS_ISSUE: begin
          if (upper > lower) begin
            mid_q <= mid;
            state <= S_BS_WAIT;
          end else begin
            scan_idx <= scan_start;
            scan_end <= (chunk_end > {1'b0, entry_count}) ? entry_count
                        : chunk_end[sipm_pkg::CNT_W-1:0];
            rd_pend  <= 1'b0;
            state    <= S_SCAN;
          end
        end
        S_BS_WAIT: begin
          if (sum_rdata > query) begin
            upper <= mid_q - sipm_pkg::SUM_AW'(1);
          end else begin
            lower <= mid_q;
          end
          state <= S_BS_ISSUE;
        end
        S_SCAN: begin
          // Issue one read per cycle; compare the data of the previous read.
          if (scan_idx < scan_end) begin
            scan_idx <= scan_idx + sipm_pkg::CNT_W'(1);
            rd_pend  <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend && ent_key <= query) begin
            res.found_index_position <= ent_key;
            res.found_file_position  <= ent_fpos;
          end
          if (!(scan_idx < scan_end) && !rd_pend) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: hold the result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
      out_item  <= res;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block took an item but did not go busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= sipm_pkg::CNT_W'(sipm_pkg::MAX_ENTRIES))
    else $error("entry count beyond table size");

  a_counts_agree: assert property (@(posedge clk) disable iff (rst)
    (entry_count == '0) == (summary_count == '0))
    else $error("summary count out of step with entry count");

  a_search_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_BS_ISSUE || state == S_BS_WAIT) |-> lower <= upper)
    else $error("binary search bounds crossed");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> scan_idx <= scan_end && scan_end <= entry_count)
    else $error("chunk scan outside the table");
`endif

endmodule

`default_nettype wire
